// ===== design/das_pkg.sv =====
// Shared types and constants for the directional anchor stepper.
// No dependencies; imported by every module of the block.
package das_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int LIVE_W       = $clog2(MAX_ENTRIES + 1);
    localparam int COUNT_W      = 7;
    localparam int COORD_W      = 12;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int COST_W       = COORD_W + 2;
    localparam int CROSS_WEIGHT = 3;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 8;
    localparam int DIR_W        = 3;

    localparam logic [DIR_W-1:0] DIR_NONE = 3'd4;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_SELECT = 2'd1,
        REQ_STEP   = 2'd2
    } das_req_type_t;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } das_dir_t;

    typedef enum logic {
        REG_ENTRY_COUNT = 1'b0,
        REG_PREVIEW     = 1'b1
    } das_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL_CHK,
        ST_CUR_LATCH,
        ST_SCAN,
        ST_FINISH
    } das_state_t;

    typedef struct packed {
        logic [IN_DATA_W-35:0] pad;
        logic [DIR_W-1:0]      direction;
        logic                  entry_playable;
        logic [COORD_W-1:0]    anchor_y;
        logic [COORD_W-1:0]    anchor_x;
        logic [5:0]            entry_index;
    } das_req_t;

    typedef struct packed {
        logic [5:0] selected_entry;
        logic       selection_valid;
        logic       moved;
    } das_result_t;

    typedef struct packed {
        logic               playable;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } das_entry_t;

    typedef struct packed {
        logic              ahead;
        logic [COST_W-1:0] cost;
    } das_cost_t;

endpackage

// ===== design/das_cost.sv =====
// Shared cost unit: forward test and along plus weighted cross distance.
// Depends on das_pkg.
module das_cost
    import das_pkg::*;
(
    input  das_dir_t           dir,
    input  logic [COORD_W-1:0] from_x,
    input  logic [COORD_W-1:0] from_y,
    input  logic [COORD_W-1:0] to_x,
    input  logic [COORD_W-1:0] to_y,
    output das_cost_t          result
);

    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic signed [DIFF_W-1:0] along;
    logic signed [DIFF_W-1:0] across;
    logic [COORD_W-1:0]       across_abs;

    assign diff_x = signed'({1'b0, to_x}) - signed'({1'b0, from_x});
    assign diff_y = signed'({1'b0, to_y}) - signed'({1'b0, from_y});

    always_comb
    begin
        unique case (dir)
            DIR_LEFT:
            begin
                along  = -diff_x;
                across = diff_y;
            end
            DIR_RIGHT:
            begin
                along  = diff_x;
                across = diff_y;
            end
            DIR_UP:
            begin
                along  = -diff_y;
                across = diff_x;
            end
            DIR_DOWN:
            begin
                along  = diff_y;
                across = diff_x;
            end
        endcase
    end

    always_comb
    begin
        if (across[DIFF_W-1])
            across_abs = COORD_W'(-across);
        else
            across_abs = across[COORD_W-1:0];
    end

    // strictly ahead: along distance positive
    assign result.ahead = !along[DIFF_W-1] && (along != '0);
    assign result.cost  = COST_W'(along[COORD_W-1:0])
                        + COST_W'(across_abs) * COST_W'(CROSS_WEIGHT);

endmodule

// ===== design/directional_anchor_stepper.sv =====
// Directional anchor stepper, top level.
// Load, reserved request, refused step, out-of-range select: straight to ST_FINISH.
// Other select: ST_SEL_CHK. Step: ST_CUR_LATCH if a selection is held, then ST_SCAN,
// one table read per cycle through the single memory port into the shared cost unit.
// One item in flight; the next is taken once the result sits in the output register.
// Reset clears selection, registers and handshake state; the table is not cleared.
module directional_anchor_stepper
    import das_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [COUNT_W-1:0]    cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [5:0] entry_index, [17:6] anchor_x, [29:18] anchor_y,
    // [30] entry_playable, [33:31] direction, [39:34] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] moved, [1] selection_valid, [7:2] selected_entry
    output logic [OUT_DATA_W-1:0] m_tdata
);

    das_state_t          state_reg, state_next;
    logic [COUNT_W-1:0]  entry_count_reg;
    logic                preview_reg;
    logic                has_sel_reg, has_sel_next;
    logic [IDX_W-1:0]    sel_idx_reg, sel_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic                eval_valid_reg, eval_valid_next;
    logic                best_valid_reg, best_valid_next;

    das_result_t         out_data_reg, out_data_next;
    logic [IDX_W-1:0]    req_idx_reg, req_idx_next;
    das_dir_t            dir_reg, dir_next;
    logic                first_mode_reg, first_mode_next;
    logic [COORD_W-1:0]  fx_reg, fx_next;
    logic [COORD_W-1:0]  fy_reg, fy_next;
    logic [LIVE_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic [IDX_W-1:0]    eval_idx_reg, eval_idx_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [COST_W-1:0]   best_cost_reg, best_cost_next;
    logic                moved_reg, moved_next;

    das_entry_t          mem [MAX_ENTRIES];
    das_entry_t          rdata_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    rd_addr;

    das_req_t            req;
    das_req_type_t       req_type;
    logic                in_xfer;
    logic [LIVE_W-1:0]   live_n;
    das_cost_t           cost;
    logic                cand;

    assign req      = das_req_t'(s_tdata);
    assign req_type = das_req_type_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // counts above the table size act as the table size
    assign live_n = (entry_count_reg > COUNT_W'(MAX_ENTRIES))
                  ? LIVE_W'(MAX_ENTRIES) : LIVE_W'(entry_count_reg);

    das_cost u_cost (
        .dir    (dir_reg),
        .from_x (fx_reg),
        .from_y (fy_reg),
        .to_x   (rdata_reg.x),
        .to_y   (rdata_reg.y),
        .result (cost)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[req.entry_index[IDX_W-1:0]] <= '{playable: req.entry_playable,
                                                 y: req.anchor_y,
                                                 x: req.anchor_x};
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            preview_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (das_reg_t'(cfg_index))
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data;
                REG_PREVIEW:     preview_reg     <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            has_sel_reg    <= 1'b0;
            sel_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
            eval_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            has_sel_reg    <= has_sel_next;
            sel_idx_reg    <= sel_idx_next;
            out_valid_reg  <= out_valid_next;
            eval_valid_reg <= eval_valid_next;
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        req_idx_reg    <= req_idx_next;
        dir_reg        <= dir_next;
        first_mode_reg <= first_mode_next;
        fx_reg         <= fx_next;
        fy_reg         <= fy_next;
        issue_cnt_reg  <= issue_cnt_next;
        eval_idx_reg   <= eval_idx_next;
        best_idx_reg   <= best_idx_next;
        best_cost_reg  <= best_cost_next;
        moved_reg      <= moved_next;
    end

    // candidate held in rdata_reg this cycle
    assign cand = rdata_reg.playable
               && (first_mode_reg || ((eval_idx_reg != sel_idx_reg) && cost.ahead));

    always_comb
    begin
        state_next      = state_reg;
        has_sel_next    = has_sel_reg;
        sel_idx_next    = sel_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        eval_valid_next = eval_valid_reg;
        best_valid_next = best_valid_reg;
        req_idx_next    = req_idx_reg;
        dir_next        = dir_reg;
        first_mode_next = first_mode_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        issue_cnt_next  = issue_cnt_reg;
        eval_idx_next   = eval_idx_reg;
        best_idx_next   = best_idx_reg;
        best_cost_next  = best_cost_reg;
        moved_next      = moved_reg;
        mem_we          = 1'b0;
        rd_addr         = issue_cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    moved_next = 1'b0;
                    state_next = ST_FINISH;
                    case (req_type)
                        REQ_LOAD:
                        begin
                            mem_we = 1'b1;
                        end
                        REQ_SELECT:
                        begin
                            if (LIVE_W'(req.entry_index) < live_n)
                            begin
                                rd_addr      = req.entry_index[IDX_W-1:0];
                                req_idx_next = req.entry_index[IDX_W-1:0];
                                state_next   = ST_SEL_CHK;
                            end
                            else
                            begin
                                has_sel_next = 1'b0;
                                sel_idx_next = '0;
                            end
                        end
                        REQ_STEP:
                        begin
                            dir_next        = das_dir_t'(req.direction[1:0]);
                            issue_cnt_next  = '0;
                            eval_valid_next = 1'b0;
                            best_valid_next = 1'b0;
                            if (preview_reg || (req.direction >= DIR_NONE)
                                || (live_n == '0))
                                state_next = ST_FINISH;
                            else if (!has_sel_reg)
                            begin
                                first_mode_next = 1'b1;
                                state_next      = ST_SCAN;
                            end
                            else
                            begin
                                // fetch the current anchor first
                                rd_addr         = sel_idx_reg;
                                first_mode_next = 1'b0;
                                state_next      = ST_CUR_LATCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SEL_CHK:
            begin
                if (rdata_reg.playable)
                begin
                    has_sel_next = 1'b1;
                    sel_idx_next = req_idx_reg;
                end
                state_next = ST_FINISH;
            end
            ST_CUR_LATCH:
            begin
                fx_next    = rdata_reg.x;
                fy_next    = rdata_reg.y;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // issue one read and judge the previous one each cycle
                if (issue_cnt_reg < live_n)
                begin
                    eval_valid_next = 1'b1;
                    eval_idx_next   = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next  = issue_cnt_reg + LIVE_W'(1);
                end
                else
                    eval_valid_next = 1'b0;

                if (eval_valid_reg && cand
                    && (!best_valid_reg || (!first_mode_reg && (cost.cost < best_cost_reg))))
                begin
                    best_valid_next = 1'b1;
                    best_idx_next   = eval_idx_reg;
                    best_cost_next  = cost.cost;
                end

                if ((issue_cnt_reg == live_n) && !eval_valid_reg)
                begin
                    if (best_valid_reg)
                    begin
                        has_sel_next = 1'b1;
                        sel_idx_next = best_idx_reg;
                        moved_next   = 1'b1;
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.moved           = moved_reg;
                    out_data_next.selection_valid = has_sel_reg;
                    out_data_next.selected_entry  = has_sel_reg
                                                  ? 6'(sel_idx_reg) : 6'd0;
                    state_next                    = ST_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== design/das_checker.sv =====
// Port-level checks for the directional anchor stepper, bound to the top.
// Depends on das_pkg and directional_anchor_stepper.
module das_checker
    import das_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_we,
    input logic                  cfg_index,
    input logic [COUNT_W-1:0]    cfg_data,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [1:0]            s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> m_tdata[7:2] == 6'd0)
        else $error("index reported without a selection");

    a_moved_sel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("move reported without a selection");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while busy");

endmodule

bind directional_anchor_stepper das_checker u_das_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for directional_anchor_stepper: directed and random request traffic, each
// result checked against a behavioural model of the anchor table and the selection.
// Depends on das_pkg and the directional_anchor_stepper RTL.
module tb;
    import das_pkg::*;

    localparam logic [1:0]       REQ_RESERVED    = 2'd3;
    localparam logic [DIR_W-1:0] GO_LEFT         = {1'b0, DIR_LEFT};
    localparam logic [DIR_W-1:0] GO_RIGHT        = {1'b0, DIR_RIGHT};
    localparam logic [DIR_W-1:0] GO_UP           = {1'b0, DIR_UP};
    localparam logic [DIR_W-1:0] GO_DOWN         = {1'b0, DIR_DOWN};
    localparam logic [DIR_W-1:0] DIR_CODE_TOP    = 3'd7;
    localparam int               IDLE_PERCENT    = 22;
    localparam int               HOLD_OFF_CYCLES = 400;
    localparam int               DRAIN_CYCLES    = 100;
    localparam int               DRAIN_LIMIT     = 20000;
    localparam int               PRINT_LIMIT     = 100;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    das_reg_t              cfg_index = REG_ENTRY_COUNT;
    logic [COUNT_W-1:0]    cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = REQ_LOAD;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Behavioural copy of the block
    logic [COORD_W-1:0] anchor_x_mem [MAX_ENTRIES];
    logic [COORD_W-1:0] anchor_y_mem [MAX_ENTRIES];
    logic               playable_mem [MAX_ENTRIES];
    bit                 loaded       [MAX_ENTRIES];
    bit                 holding      = 1'b0;
    logic [IDX_W-1:0]   held_index   = '0;
    logic [COUNT_W-1:0] entry_count_reg = '0;
    logic               preview_reg  = 1'b0;

    das_result_t selection_queue[$];
    int          mismatches   = 0;
    bit          calm         = 1'b0;
    bit          hold_off_req = 1'b0;

    directional_anchor_stepper DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int live_entries();
        return (entry_count_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_count_reg);
    endfunction

    function automatic void pick_entry(int i);
        if (i < live_entries())
        begin
            if (playable_mem[i])
            begin
                holding    = 1'b1;
                held_index = IDX_W'(i);
            end
        end
        else
        begin
            holding    = 1'b0;
            held_index = '0;
        end
    endfunction

    function automatic bit step_selection(logic [DIR_W-1:0] dir);
        int n, best, best_cost, from_x, from_y, tx, ty, along, across, cost;
        n         = live_entries();
        best      = -1;
        best_cost = 0;
        // codes 4 and up all carry bit 2: no direction
        if (preview_reg || dir[2] || n == 0)
            return 1'b0;
        if (!holding)
        begin
            for (int i = 0; i < n; i++)
                if (best < 0 && playable_mem[i])
                    best = i;
        end
        else
        begin
            from_x = anchor_x_mem[held_index];
            from_y = anchor_y_mem[held_index];
            for (int i = 0; i < n; i++)
            begin
                if (i != held_index && playable_mem[i])
                begin
                    tx = anchor_x_mem[i];
                    ty = anchor_y_mem[i];
                    case (das_dir_t'(dir[1:0]))
                        DIR_LEFT:
                        begin
                            along  = from_x - tx;
                            across = ty - from_y;
                        end
                        DIR_RIGHT:
                        begin
                            along  = tx - from_x;
                            across = ty - from_y;
                        end
                        DIR_UP:
                        begin
                            along  = from_y - ty;
                            across = tx - from_x;
                        end
                        default:
                        begin
                            along  = ty - from_y;
                            across = tx - from_x;
                        end
                    endcase
                    if (along > 0)
                    begin
                        if (across < 0)
                            across = -across;
                        cost = along + CROSS_WEIGHT * across;
                        // strict compare keeps the earliest entry on a tie
                        if (best < 0 || cost < best_cost)
                        begin
                            best      = i;
                            best_cost = cost;
                        end
                    end
                end
            end
        end
        if (best < 0)
            return 1'b0;
        pick_entry(best);
        return 1'b1;
    endfunction

    function automatic das_result_t predict_selection(logic [1:0] kind, das_req_t req);
        das_result_t res;
        res.moved = 1'b0;
        case (kind)
            REQ_LOAD:
            begin
                anchor_x_mem[req.entry_index] = req.anchor_x;
                anchor_y_mem[req.entry_index] = req.anchor_y;
                playable_mem[req.entry_index] = req.entry_playable;
                loaded[req.entry_index]       = 1'b1;
            end
            REQ_SELECT: pick_entry(req.entry_index);
            REQ_STEP:   res.moved = step_selection(req.direction);
            default:    ;
        endcase
        res.selection_valid = holding;
        res.selected_entry  = holding ? held_index : '0;
        return res;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        das_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (selection_queue.size() == 0)
                flag_mismatch("unexpected result", got, 0);
            else
            begin
                want = selection_queue.pop_front();
                if (got.moved !== want.moved)
                    flag_mismatch("moved", got.moved, want.moved);
                if (got.selection_valid !== want.selection_valid)
                    flag_mismatch("selection_valid", got.selection_valid, want.selection_valid);
                if (got.selected_entry !== want.selected_entry)
                    flag_mismatch("selected_entry", got.selected_entry, want.selected_entry);
            end
        end
    end

    // Result side: random stalls, or a long counted hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge clk);
        end
    end

    // Offer one item, hold it until the transfer, then record what it should produce.
    // Valid stays high afterwards so that the next item can follow without a gap.
    task automatic send_request(logic [1:0] kind, das_req_t req);
        das_result_t expected;
        if (!calm)
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected        = predict_selection(kind, req);
        selection_queue = {selection_queue, expected};
    endtask

    // Write both registers once the block has drained
    task automatic write_regs(logic [COUNT_W-1:0] count, logic preview);
        s_tvalid <= 1'b0;
        while (selection_queue.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ENTRY_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        entry_count_reg = count;
        cfg_index <= REG_PREVIEW;
        cfg_data  <= COUNT_W'(preview);
        @(posedge clk);
        preview_reg = preview;
        cfg_we <= 1'b0;
    endtask

    function automatic das_req_t random_req();
        das_req_t req;
        req                = '0;
        req.entry_index    = IDX_W'($urandom);
        req.anchor_x       = COORD_W'($urandom);
        req.anchor_y       = COORD_W'($urandom);
        req.entry_playable = 1'($urandom);
        req.direction      = DIR_W'($urandom);
        return req;
    endfunction

    // Mostly a tight cluster, so that steps meet ties and coincident anchors
    function automatic logic [COORD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(9);
        if (r < 6)
            return COORD_W'(2048 + $urandom_range(7));
        if (r < 8)
            return COORD_W'($urandom);
        return (r == 8) ? '0 : '1;
    endfunction

    function automatic das_req_t random_load(int idx);
        das_req_t req;
        req                = random_req();
        req.entry_index    = IDX_W'(idx);
        req.anchor_x       = pick_coord();
        req.anchor_y       = pick_coord();
        req.entry_playable = ($urandom_range(9) < 8);
        return req;
    endfunction

    task automatic load_anchor(int idx, int x, int y, bit playable);
        das_req_t req;
        req                = '0;
        req.entry_index    = IDX_W'(idx);
        req.anchor_x       = COORD_W'(x);
        req.anchor_y       = COORD_W'(y);
        req.entry_playable = playable;
        send_request(REQ_LOAD, req);
    endtask

    task automatic request_select(int idx);
        das_req_t req;
        req             = '0;
        req.entry_index = IDX_W'(idx);
        send_request(REQ_SELECT, req);
    endtask

    task automatic request_step(logic [DIR_W-1:0] dir);
        das_req_t req;
        req           = '0;
        req.direction = dir;
        send_request(REQ_STEP, req);
    endtask

    task automatic send_random_request();
        das_req_t req;
        int       r, n;
        r = $urandom_range(99);
        n = live_entries();
        if (r < 18)
            send_request(REQ_LOAD, random_load($urandom_range(MAX_ENTRIES - 1)));
        else if (r < 38)
        begin
            req = random_req();
            if (n > 0 && $urandom_range(9) < 7)
                req.entry_index = IDX_W'($urandom_range(n - 1));
            send_request(REQ_SELECT, req);
        end
        else if (r < 96)
        begin
            req = random_req();
            req.direction = ($urandom_range(9) < 9) ? DIR_W'($urandom_range(3))
                                                    : DIR_W'($urandom_range(4, 7));
            send_request(REQ_STEP, req);
        end
        else
            send_request(REQ_RESERVED, random_req());
    endtask

    // Load every live entry not yet written, so no step or select reads an empty slot
    task automatic run_phase(logic [COUNT_W-1:0] count, logic preview, int items);
        write_regs(count, preview);
        for (int i = 0; i < live_entries(); i++)
            if (!loaded[i])
                send_request(REQ_LOAD, random_load(i));
        repeat (items)
            send_random_request();
    endtask

    task automatic test_empty_table();
        request_step(GO_RIGHT);
        request_select(5);
    endtask

    task automatic test_table_load();
        load_anchor(0, 0, 0, 1'b0);
        load_anchor(1, 200, 200, 1'b1);
        load_anchor(2, 201, 201, 1'b1);
        load_anchor(3, 204, 200, 1'b1);
        load_anchor(4, 200, 200, 1'b1);
        load_anchor(5, 4095, 4095, 1'b1);
        load_anchor(6, 0, 4095, 1'b1);
        load_anchor(7, 4095, 0, 1'b0);
        write_regs(8, 1'b0);
    endtask

    task automatic test_step_rules();
        request_step(DIR_NONE);
        request_step(DIR_CODE_TOP);
        request_step(GO_LEFT);      // no selection yet: first playable entry
        request_step(GO_RIGHT);     // two candidates at equal cost
        request_step(GO_DOWN);
        request_step(GO_UP);
    endtask

    task automatic test_selection_rules();
        request_select(0);
        request_select(7);
        request_select(8);
        request_select(4);
        send_request(REQ_RESERVED, '0);
    endtask

    task automatic test_preview_mode();
        write_regs(8, 1'b1);
        request_step(GO_RIGHT);
        write_regs(8, 1'b0);
    endtask

    task automatic test_stale_selection();
        request_select(6);
        write_regs(3, 1'b0);
        request_step(GO_RIGHT);
    endtask

    task automatic test_random_traffic();
        run_phase(7'd64, 1'b0, 60);
        run_phase(7'd127, 1'b0, 60);
        run_phase(7'd1, 1'b0, 30);
        run_phase(7'd0, 1'b0, 20);
        run_phase(COUNT_W'($urandom_range(2, 127)), 1'b0, 60);
        run_phase(COUNT_W'($urandom_range(2, 127)), 1'b1, 30);
        run_phase(COUNT_W'($urandom_range(2, 64)), 1'b0, 60);
        run_phase(COUNT_W'($urandom_range(65, 127)), 1'b0, 60);
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        run_phase(7'd64, 1'b0, 60);
        calm = 1'b0;
    endtask

    // Keep offering while results are held back, so the input stalls
    task automatic test_output_hold_off();
        write_regs(7'd64, 1'b0);
        calm         = 1'b1;
        hold_off_req = 1'b1;
        repeat (50)
            send_random_request();
        calm = 1'b0;
    endtask

    initial
    begin
        int drain;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_table_load();
        test_step_rules();
        test_selection_rules();
        test_preview_mode();
        test_stale_selection();
        test_random_traffic();
        test_back_to_back();
        test_output_hold_off();

        s_tvalid <= 1'b0;
        drain = 0;
        while (selection_queue.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (selection_queue.size() != 0)
            flag_mismatch("results never delivered", 0, selection_queue.size());
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("[directional_anchor_stepper] OK");
        else
            $display("[directional_anchor_stepper] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[directional_anchor_stepper] ERROR");
        $finish;
    end

endmodule

// ===== directional_anchor_stepper.f =====
design/das_pkg.sv
design/das_cost.sv
design/directional_anchor_stepper.sv
design/das_checker.sv
tb/tb.sv
